// ===== design/mdj_pkg.sv =====
// package for the motorised door jam controller
// holds channel payload types, event and register codes and reset values
// no dependencies
package mdj_pkg;

    // input event codes
    typedef enum logic [2:0] {
        KIND_TICK     = 3'd0,
        KIND_OPEN     = 3'd1,
        KIND_CLOSE    = 3'd2,
        KIND_DISPENSE = 3'd3,
        KIND_OK       = 3'd4
    } kind_t;

    // reported event codes
    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_TRAVEL_DONE   = 3'd1,
        EV_JAM_FOUND     = 3'd2,
        EV_JAM_CLEARED   = 3'd3,
        EV_DISPENSE_DONE = 3'd4
    } event_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TRAVEL_TICKS = 3'd0,
        CFG_RETRY_TICKS  = 3'd1,
        CFG_LIGHT_HIGH   = 3'd2,
        CFG_LIGHT_LOW    = 3'd3,
        CFG_MOTOR_DUTY   = 3'd4
    } cfg_idx_t;

    localparam int LIGHT_BITS = 10;
    localparam int COUNT_BITS = 8;
    localparam int DUTY_BITS  = 8;
    localparam int CFG_DATA_BITS = 10;

    // register reset values
    localparam logic [COUNT_BITS-1:0] TRAVEL_TICKS_RST = 8'd25;
    localparam logic [COUNT_BITS-1:0] RETRY_TICKS_RST  = 8'd10;
    localparam logic [LIGHT_BITS-1:0] LIGHT_HIGH_RST   = 10'd40;
    localparam logic [LIGHT_BITS-1:0] LIGHT_LOW_RST    = 10'd20;
    localparam logic [DUTY_BITS-1:0]  MOTOR_DUTY_RST   = 8'd250;

    // input transaction payload
    typedef struct packed {
        logic [2:0]            kind;
        logic [LIGHT_BITS-1:0] light_level;
    } in_item_t;

    // result transaction payload
    typedef struct packed {
        logic [DUTY_BITS-1:0] drive_duty;
        logic                 toward_open_out;
        logic                 brake_on;
        logic                 is_open;
        logic                 is_moving;
        logic                 is_dispensing;
        logic                 is_jammed;
        logic [2:0]           event_res;
    } out_item_t;

endpackage

// ===== design/mdj_in_if.sv =====
// input event channel of the door jam controller
// depends on mdj_pkg
interface mdj_in_if;
    logic              valid;
    logic              ready;
    mdj_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mdj_out_if.sv =====
// result channel of the door jam controller
// depends on mdj_pkg
interface mdj_out_if;
    logic               valid;
    logic               ready;
    mdj_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/mdj_cfg_if.sv =====
// configuration write channel of the door jam controller
// depends on mdj_pkg
interface mdj_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        index;
    logic [mdj_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/motor_door_jam_controller_top.sv =====
// motorised door sequencer with light-sensor jam detection and ok-driven retry
// a result is registered and valid the cycle after its input is accepted
// throughput: one transaction per cycle unless results stall; the state update
// is a single pass between the state registers and the result register
// reset: door closed and stopped, no jam, counter zero, registers at defaults
// depends on mdj_pkg, mdj_in_if, mdj_out_if, mdj_cfg_if
module motor_door_jam_controller_top #(
    parameter int TICK_COUNT_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    mdj_in_if.sink    in_ch,
    mdj_out_if.source out_ch,
    mdj_cfg_if.sink   cfg_ch
);

    // width wide enough for both a loaded count and the counter range
    localparam int CW = (TICK_COUNT_BITS > mdj_pkg::COUNT_BITS) ?
                        TICK_COUNT_BITS : mdj_pkg::COUNT_BITS;
    localparam logic [CW-1:0] TICK_MAX = CW'((1 << TICK_COUNT_BITS) - 1);

    // configuration registers
    logic [mdj_pkg::COUNT_BITS-1:0] travel_ticks_reg;
    logic [mdj_pkg::COUNT_BITS-1:0] retry_ticks_reg;
    logic [mdj_pkg::LIGHT_BITS-1:0] light_high_reg;
    logic [mdj_pkg::LIGHT_BITS-1:0] light_low_reg;
    logic [mdj_pkg::DUTY_BITS-1:0]  motor_duty_reg;

    // door state
    logic door_open_reg, door_open_next;
    logic door_moving_reg, door_moving_next;
    logic toward_open_reg, toward_open_next;
    logic dispensing_reg, dispensing_next;
    logic jammed_reg, jammed_next;
    logic ok_latched_reg, ok_latched_next;
    logic retrying_reg, retrying_next;
    logic [TICK_COUNT_BITS-1:0] ticks_left_reg, ticks_left_next;

    // result register
    logic               out_valid_reg;
    mdj_pkg::out_item_t out_data_reg, out_data_next;

    logic in_accept;
    logic [TICK_COUNT_BITS-1:0] ticks_dec;
    logic                       count_done;
    logic [TICK_COUNT_BITS-1:0] travel_load;
    logic [TICK_COUNT_BITS-1:0] retry_load;
    logic                       jam_if_open;
    logic                       jam_if_closed;
    logic [2:0]                 ev;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign in_accept    = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travel_ticks_reg <= mdj_pkg::TRAVEL_TICKS_RST;
            retry_ticks_reg  <= mdj_pkg::RETRY_TICKS_RST;
            light_high_reg   <= mdj_pkg::LIGHT_HIGH_RST;
            light_low_reg    <= mdj_pkg::LIGHT_LOW_RST;
            motor_duty_reg   <= mdj_pkg::MOTOR_DUTY_RST;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                mdj_pkg::CFG_TRAVEL_TICKS: travel_ticks_reg <= cfg_ch.data[7:0];
                mdj_pkg::CFG_RETRY_TICKS:  retry_ticks_reg  <= cfg_ch.data[7:0];
                mdj_pkg::CFG_LIGHT_HIGH:   light_high_reg   <= cfg_ch.data;
                mdj_pkg::CFG_LIGHT_LOW:    light_low_reg    <= cfg_ch.data;
                mdj_pkg::CFG_MOTOR_DUTY:   motor_duty_reg   <= cfg_ch.data[7:0];
                default: ;
            endcase
        end
    end

    // counter loads saturate at the counter range
    assign travel_load = (CW'(travel_ticks_reg) > TICK_MAX) ?
                         TICK_COUNT_BITS'(TICK_MAX) : TICK_COUNT_BITS'(CW'(travel_ticks_reg));
    assign retry_load  = (CW'(retry_ticks_reg) > TICK_MAX) ?
                         TICK_COUNT_BITS'(TICK_MAX) : TICK_COUNT_BITS'(CW'(retry_ticks_reg));

    // tick countdown, stuck at zero
    assign ticks_dec  = (ticks_left_reg != '0) ? ticks_left_reg - 1'b1 : ticks_left_reg;
    assign count_done = (ticks_dec == '0);

    // light checks for either door position
    assign jam_if_open   = (in_ch.data.light_level < light_low_reg);
    assign jam_if_closed = (in_ch.data.light_level > light_high_reg);

    // next state for one event
    always_comb
    begin
        door_open_next   = door_open_reg;
        door_moving_next = door_moving_reg;
        toward_open_next = toward_open_reg;
        dispensing_next  = dispensing_reg;
        jammed_next      = jammed_reg;
        ok_latched_next  = ok_latched_reg;
        retrying_next    = retrying_reg;
        ticks_left_next  = ticks_left_reg;
        ev               = mdj_pkg::EV_NONE;

        case (in_ch.data.kind)
            mdj_pkg::KIND_TICK:
            begin
                if (jammed_reg)
                begin
                    if (retrying_reg)
                    begin
                        ticks_left_next = ticks_dec;
                        if (count_done)
                        begin
                            retrying_next    = 1'b0;
                            door_moving_next = 1'b0;
                            if (door_open_reg ? jam_if_open : jam_if_closed)
                            begin
                                ev = mdj_pkg::EV_JAM_FOUND;
                            end
                            else
                            begin
                                jammed_next = 1'b0;
                                ev          = mdj_pkg::EV_JAM_CLEARED;
                                // dispense routine carries on
                                if (dispensing_reg)
                                begin
                                    if (door_open_reg)
                                    begin
                                        toward_open_next = 1'b0;
                                        ticks_left_next  = travel_load;
                                        door_moving_next = 1'b1;
                                    end
                                    else
                                    begin
                                        dispensing_next = 1'b0;
                                        ev              = mdj_pkg::EV_DISPENSE_DONE;
                                    end
                                end
                            end
                        end
                    end
                    else if (ok_latched_reg)
                    begin
                        ok_latched_next  = 1'b0;
                        retrying_next    = 1'b1;
                        ticks_left_next  = retry_load;
                        door_moving_next = 1'b1;
                    end
                end
                else if (door_moving_reg)
                begin
                    ticks_left_next = ticks_dec;
                    if (count_done)
                    begin
                        door_moving_next = 1'b0;
                        door_open_next   = toward_open_reg;
                        if (toward_open_reg ? jam_if_open : jam_if_closed)
                        begin
                            jammed_next = 1'b1;
                            ev          = mdj_pkg::EV_JAM_FOUND;
                        end
                        else
                        begin
                            ev = mdj_pkg::EV_TRAVEL_DONE;
                            // dispense turnaround on the same tick
                            if (dispensing_reg)
                            begin
                                if (toward_open_reg)
                                begin
                                    toward_open_next = 1'b0;
                                    ticks_left_next  = travel_load;
                                    door_moving_next = 1'b1;
                                end
                                else
                                begin
                                    dispensing_next = 1'b0;
                                    ev              = mdj_pkg::EV_DISPENSE_DONE;
                                end
                            end
                        end
                    end
                end
            end
            mdj_pkg::KIND_OPEN:
            begin
                if (!jammed_reg && !door_open_reg && !door_moving_reg)
                begin
                    toward_open_next = 1'b1;
                    ticks_left_next  = travel_load;
                    door_moving_next = 1'b1;
                end
            end
            mdj_pkg::KIND_CLOSE:
            begin
                if (!jammed_reg && door_open_reg && !door_moving_reg)
                begin
                    toward_open_next = 1'b0;
                    ticks_left_next  = travel_load;
                    door_moving_next = 1'b1;
                end
            end
            mdj_pkg::KIND_DISPENSE:
            begin
                if (!jammed_reg)
                begin
                    dispensing_next = 1'b1;
                    if (!door_open_reg && !door_moving_reg)
                    begin
                        toward_open_next = 1'b1;
                        ticks_left_next  = travel_load;
                        door_moving_next = 1'b1;
                    end
                end
            end
            mdj_pkg::KIND_OK:
            begin
                ok_latched_next = 1'b1;
            end
            default: ;
        endcase
    end

    // result built from the state after the event
    always_comb
    begin
        out_data_next.drive_duty      = door_moving_next ? motor_duty_reg : '0;
        out_data_next.toward_open_out = toward_open_next;
        out_data_next.brake_on        = !door_moving_next;
        out_data_next.is_open         = door_open_next;
        out_data_next.is_moving       = door_moving_next;
        out_data_next.is_dispensing   = dispensing_next;
        out_data_next.is_jammed       = jammed_next;
        out_data_next.event_res       = ev;
    end

    // state update on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            door_open_reg   <= 1'b0;
            door_moving_reg <= 1'b0;
            toward_open_reg <= 1'b0;
            dispensing_reg  <= 1'b0;
            jammed_reg      <= 1'b0;
            ok_latched_reg  <= 1'b0;
            retrying_reg    <= 1'b0;
            ticks_left_reg  <= '0;
        end
        else if (in_accept)
        begin
            door_open_reg   <= door_open_next;
            door_moving_reg <= door_moving_next;
            toward_open_reg <= toward_open_next;
            dispensing_reg  <= dispensing_next;
            jammed_reg      <= jammed_next;
            ok_latched_reg  <= ok_latched_next;
            retrying_reg    <= retrying_next;
            ticks_left_reg  <= ticks_left_next;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // a retry only runs while jammed, with the motor going
    a_retry_needs_jam: assert property (@(posedge clk) disable iff (!rst_n)
        retrying_reg |-> (jammed_reg && door_moving_reg))
        else $error("retry active without a jam or without motor drive");

    // an ok press is latched for the next jam
    a_ok_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_ch.data.kind == mdj_pkg::KIND_OK) |=> ok_latched_reg)
        else $error("ok press not latched");

    // a latched ok starts the retry on the next tick while jammed
    a_retry_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_ch.data.kind == mdj_pkg::KIND_TICK && jammed_reg
         && !retrying_reg && ok_latched_reg) |=> (retrying_reg && !ok_latched_reg))
        else $error("retry did not start from a latched ok");

    // a stalled result keeps its valid flag
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> out_valid_reg)
        else $error("stalled result dropped");

    // reported brake always matches the motor state in the result
    a_brake_vs_moving: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (out_data_reg.brake_on == !out_data_reg.is_moving
                       && out_data_reg.is_moving == door_moving_reg))
        else $error("brake and motor state disagree");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the motorised door jam controller: directed, random and stall tests
// a built-in door model predicts each result; depends on mdj_pkg and the three channel interfaces
module testbench;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 400;
    localparam int FIRST_UNUSED_KIND = mdj_pkg::KIND_OK + 1;
    localparam int LIGHT_BITS     = mdj_pkg::LIGHT_BITS;
    localparam int COUNT_BITS     = mdj_pkg::COUNT_BITS;
    localparam int DUTY_BITS      = mdj_pkg::DUTY_BITS;
    localparam int CFG_DATA_BITS  = mdj_pkg::CFG_DATA_BITS;

    logic clk = 1'b0;
    logic rst_n;

    mdj_in_if  in_ch ();
    mdj_out_if out_ch ();
    mdj_cfg_if cfg_ch ();

    motor_door_jam_controller_top #(
        .TICK_COUNT_BITS(8)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // door model: register copies
    logic [COUNT_BITS-1:0] travel_ticks = mdj_pkg::TRAVEL_TICKS_RST;
    logic [COUNT_BITS-1:0] retry_ticks  = mdj_pkg::RETRY_TICKS_RST;
    logic [LIGHT_BITS-1:0] light_high   = mdj_pkg::LIGHT_HIGH_RST;
    logic [LIGHT_BITS-1:0] light_low    = mdj_pkg::LIGHT_LOW_RST;
    logic [DUTY_BITS-1:0]  motor_duty   = mdj_pkg::MOTOR_DUTY_RST;

    // door model: sequencer state
    logic                  door_open    = 1'b0;
    logic                  motor_on     = 1'b0;
    logic                  heading_open = 1'b0;
    logic                  dispense_on  = 1'b0;
    logic                  jam_on       = 1'b0;
    logic                  ok_held      = 1'b0;
    logic                  retry_on     = 1'b0;
    logic [COUNT_BITS-1:0] ticks_left   = '0;

    mdj_pkg::out_item_t expected_status[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_request   = 0;
    int errors         = 0;
    int n_checked      = 0;
    int n_travel       = 0;
    int n_jams         = 0;
    int n_cleared      = 0;
    int n_dispensed    = 0;
    int n_cfg_writes   = 0;

    // motor start in a given direction for a given count
    function automatic void start_motor(input logic open_dir, input logic [COUNT_BITS-1:0] count);
        heading_open = open_dir;
        ticks_left   = count;
        motor_on     = 1'b1;
    endfunction

    // counts one tick, a zero count ends on the first tick
    function automatic logic tick_expired();
        if (ticks_left != 0)
            ticks_left = ticks_left - 1'b1;
        return ticks_left == 0;
    endfunction

    function automatic logic light_jams(input logic [LIGHT_BITS-1:0] light);
        if (door_open && light < light_low)
            return 1'b1;
        if (!door_open && light > light_high)
            return 1'b1;
        return 1'b0;
    endfunction

    // dispense continues with a close, or finishes once the door is shut
    function automatic mdj_pkg::event_t advance_dispense(input mdj_pkg::event_t ev_code);
        if (!dispense_on)
            return ev_code;
        if (door_open)
        begin
            start_motor(1'b0, travel_ticks);
            return ev_code;
        end
        dispense_on = 1'b0;
        return mdj_pkg::EV_DISPENSE_DONE;
    endfunction

    // next door status for one event
    function automatic mdj_pkg::out_item_t predict_door_response(input mdj_pkg::in_item_t it);
        mdj_pkg::out_item_t status;
        mdj_pkg::event_t    ev_code;
        ev_code = mdj_pkg::EV_NONE;
        case (it.kind)
            mdj_pkg::KIND_TICK:
            begin
                if (jam_on)
                begin
                    if (retry_on)
                    begin
                        if (tick_expired())
                        begin
                            retry_on = 1'b0;
                            motor_on = 1'b0;
                            if (light_jams(it.light_level))
                                ev_code = mdj_pkg::EV_JAM_FOUND;
                            else
                            begin
                                jam_on  = 1'b0;
                                ev_code = advance_dispense(mdj_pkg::EV_JAM_CLEARED);
                            end
                        end
                    end
                    else if (ok_held)
                    begin
                        ok_held  = 1'b0;
                        retry_on = 1'b1;
                        start_motor(heading_open, retry_ticks);
                    end
                end
                else if (motor_on)
                begin
                    if (tick_expired())
                    begin
                        motor_on  = 1'b0;
                        door_open = heading_open;
                        if (light_jams(it.light_level))
                        begin
                            jam_on  = 1'b1;
                            ev_code = mdj_pkg::EV_JAM_FOUND;
                        end
                        else
                            ev_code = advance_dispense(mdj_pkg::EV_TRAVEL_DONE);
                    end
                end
            end
            mdj_pkg::KIND_OPEN:
            begin
                if (!jam_on && !door_open && !motor_on)
                    start_motor(1'b1, travel_ticks);
            end
            mdj_pkg::KIND_CLOSE:
            begin
                if (!jam_on && door_open && !motor_on)
                    start_motor(1'b0, travel_ticks);
            end
            mdj_pkg::KIND_DISPENSE:
            begin
                if (!jam_on)
                begin
                    dispense_on = 1'b1;
                    if (!door_open && !motor_on)
                        start_motor(1'b1, travel_ticks);
                end
            end
            mdj_pkg::KIND_OK:
                ok_held = 1'b1;
            default:
                ;
        endcase
        status.drive_duty      = motor_on ? motor_duty : '0;
        status.toward_open_out = heading_open;
        status.brake_on        = !motor_on;
        status.is_open         = door_open;
        status.is_moving       = motor_on;
        status.is_dispensing   = dispense_on;
        status.is_jammed       = jam_on;
        status.event_res       = ev_code;
        return status;
    endfunction

    // model update on every accepted event and register write
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
            expected_status.push_back(predict_door_response(in_ch.data));
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            n_cfg_writes++;
            case (cfg_ch.index)
                mdj_pkg::CFG_TRAVEL_TICKS: travel_ticks = cfg_ch.data[COUNT_BITS-1:0];
                mdj_pkg::CFG_RETRY_TICKS:  retry_ticks  = cfg_ch.data[COUNT_BITS-1:0];
                mdj_pkg::CFG_LIGHT_HIGH:   light_high   = cfg_ch.data;
                mdj_pkg::CFG_LIGHT_LOW:    light_low    = cfg_ch.data;
                mdj_pkg::CFG_MOTOR_DUTY:   motor_duty   = cfg_ch.data[DUTY_BITS-1:0];
                default:                   ;
            endcase
        end
    end

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result checker against the oldest expectation
    always @(posedge clk)
    begin
        mdj_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected result transaction, expected none, actual %p",
                         $time, out_ch.data);
                errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                n_checked++;
                check_field("drive_duty", want.drive_duty, out_ch.data.drive_duty);
                check_field("toward_open_out", want.toward_open_out, out_ch.data.toward_open_out);
                check_field("brake_on", want.brake_on, out_ch.data.brake_on);
                check_field("is_open", want.is_open, out_ch.data.is_open);
                check_field("is_moving", want.is_moving, out_ch.data.is_moving);
                check_field("is_dispensing", want.is_dispensing, out_ch.data.is_dispensing);
                check_field("is_jammed", want.is_jammed, out_ch.data.is_jammed);
                check_field("event_res", want.event_res, out_ch.data.event_res);
                case (want.event_res)
                    mdj_pkg::EV_TRAVEL_DONE:   n_travel++;
                    mdj_pkg::EV_JAM_FOUND:     n_jams++;
                    mdj_pkg::EV_JAM_CLEARED:   n_cleared++;
                    mdj_pkg::EV_DISPENSE_DONE: n_dispensed++;
                    default:                   ;
                endcase
            end
        end
    end

    // result side ready, random stalls and long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // one event transaction, with a random gap ahead of it
    task automatic send_item(input logic [2:0] kind, input logic [LIGHT_BITS-1:0] light);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.data.kind        <= kind;
        in_ch.data.light_level <= light;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // stop offering and wait until every result is back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input mdj_pkg::cfg_idx_t idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // all registers written while the block is idle
    task automatic set_config(input logic [CFG_DATA_BITS-1:0] travel,
                              input logic [CFG_DATA_BITS-1:0] retry,
                              input logic [CFG_DATA_BITS-1:0] high,
                              input logic [CFG_DATA_BITS-1:0] low,
                              input logic [CFG_DATA_BITS-1:0] duty);
        wait_drained();
        write_reg(mdj_pkg::CFG_TRAVEL_TICKS, travel);
        write_reg(mdj_pkg::CFG_RETRY_TICKS, retry);
        write_reg(mdj_pkg::CFG_LIGHT_HIGH, high);
        write_reg(mdj_pkg::CFG_LIGHT_LOW, low);
        write_reg(mdj_pkg::CFG_MOTOR_DUTY, duty);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // short moves and thresholds spread over the sensor range
    task automatic random_small_config();
        set_config(CFG_DATA_BITS'($urandom_range(5)), CFG_DATA_BITS'($urandom_range(5)),
                   CFG_DATA_BITS'($urandom_range(1023)), CFG_DATA_BITS'($urandom_range(1023)),
                   CFG_DATA_BITS'($urandom_range(1023)));
    endtask

    // mostly ticks, light often on a threshold edge
    function automatic mdj_pkg::in_item_t random_event();
        mdj_pkg::in_item_t     it;
        int                    pick;
        logic [LIGHT_BITS-1:0] edge_level;
        pick = $urandom_range(99);
        if (pick < 68)
            it.kind = mdj_pkg::KIND_TICK;
        else if (pick < 75)
            it.kind = mdj_pkg::KIND_OPEN;
        else if (pick < 81)
            it.kind = mdj_pkg::KIND_CLOSE;
        else if (pick < 87)
            it.kind = mdj_pkg::KIND_DISPENSE;
        else if (pick < 96)
            it.kind = mdj_pkg::KIND_OK;
        else
            it.kind = 3'($urandom_range(7, FIRST_UNUSED_KIND));
        pick = $urandom_range(9);
        edge_level = $urandom_range(1) ? light_high : light_low;
        if (pick < 4)
            it.light_level = edge_level + LIGHT_BITS'($urandom_range(2)) - 1'b1;
        else if (pick == 4)
            it.light_level = $urandom_range(1) ? '1 : '0;
        else
            it.light_level = LIGHT_BITS'($urandom_range(1023));
        return it;
    endfunction

    task automatic run_random_events(input int count, input int src_pct, input int sink_pct);
        mdj_pkg::in_item_t it;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (count)
        begin
            it = random_event();
            send_item(it.kind, it.light_level);
        end
    endtask

    // reset values: full default travel, default duty and the lower light bound
    task automatic test_reset_defaults();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_item(mdj_pkg::KIND_OK, '0);
        send_item(mdj_pkg::KIND_OPEN, '0);
        repeat (24) send_item(mdj_pkg::KIND_TICK, '1);
        send_item(mdj_pkg::KIND_TICK, mdj_pkg::LIGHT_LOW_RST);
        wait_drained();
    endtask

    // jams, retries with a zero count, ignored requests and dispense runs
    task automatic test_jam_retry_dispense();
        set_config(10'd1, 10'd0, 10'd0, '1, '1);
        send_item(mdj_pkg::KIND_CLOSE, '0);
        send_item(mdj_pkg::KIND_TICK, 10'd1);
        send_item(mdj_pkg::KIND_DISPENSE, '0);
        send_item(mdj_pkg::KIND_TICK, '0);
        send_item(mdj_pkg::KIND_TICK, '0);
        send_item(mdj_pkg::KIND_DISPENSE, '0);
        send_item(mdj_pkg::KIND_TICK, '1);
        send_item(mdj_pkg::KIND_TICK, '0);
        // dispense requested while the door is already moving
        send_item(mdj_pkg::KIND_OPEN, '0);
        send_item(mdj_pkg::KIND_DISPENSE, '0);
        send_item(mdj_pkg::KIND_TICK, '1);
        send_item(mdj_pkg::KIND_TICK, '1);
        send_item(mdj_pkg::KIND_OK, '0);
        send_item(mdj_pkg::KIND_TICK, '0);
        send_item(mdj_pkg::KIND_TICK, '0);
        // retry that finds the jam again
        send_item(mdj_pkg::KIND_OPEN, '0);
        send_item(mdj_pkg::KIND_TICK, '0);
        send_item(mdj_pkg::KIND_TICK, '0);
        send_item(mdj_pkg::KIND_OK, '0);
        send_item(mdj_pkg::KIND_TICK, '0);
        send_item(mdj_pkg::KIND_TICK, '0);
        send_item(mdj_pkg::KIND_OK, '0);
        send_item(mdj_pkg::KIND_TICK, '0);
        send_item(mdj_pkg::KIND_TICK, '1);
        wait_drained();
    endtask

    // random traffic through several settings and idling mixes
    task automatic test_random_traffic();
        random_small_config();
        run_random_events(260, 0, 0);
        // nearly every end of travel jams
        set_config(CFG_DATA_BITS'($urandom_range(3)), CFG_DATA_BITS'($urandom_range(3)),
                   10'd0, '1, CFG_DATA_BITS'($urandom_range(255)));
        run_random_events(260, 63, 0);
        // longest counts, never a jam, zero duty
        set_config(10'd255, 10'd255, '1, 10'd0, 10'd0);
        run_random_events(260, 0, 63);
        random_small_config();
        run_random_events(260, 14, 14);
        wait_drained();
    endtask

    // long receiver hold-off while events keep coming
    task automatic test_backpressure();
        random_small_config();
        hold_request = LONG_HOLD;
        run_random_events(260, 0, 30);
        wait_drained();
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.data             = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = mdj_pkg::CFG_TRAVEL_TICKS;
        cfg_ch.data            = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_jam_retry_dispense();
        test_random_traffic();
        test_backpressure();
        repeat (4) @(posedge clk);

        $display("checked %0d results over %0d register writes", n_checked, n_cfg_writes);
        $display("seen %0d travel ends, %0d jams, %0d jams cleared, %0d dispenses done",
                 n_travel, n_jams, n_cleared, n_dispensed);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
